>>> design/pssr_pkg.sv
// ----------------------------------------------------------------------------
// pssr_pkg
// Shared types and codes for the parity-split sorted set with rank query.
// ----------------------------------------------------------------------------
package pssr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned StatW  = 2;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] ST_INSERTED = 2'd0;
  localparam logic [StatW-1:0] ST_PRESENT  = 2'd1;
  localparam logic [StatW-1:0] ST_FULL     = 2'd2;
  localparam logic [StatW-1:0] ST_LOOKUP   = 2'd3;

  // what the token is doing as it walks the chain
  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_SHIFT,
    MODE_DONE
  } mode_e;

  // token handed from cell to cell
  typedef struct packed {
    logic                     vld;
    mode_e                    mode;
    logic                     func;
    logic                     odd;
    logic                     full;
    logic [ValueW-1:0]        key;
    logic [StatW-1:0]         status;
    logic [PosW-1:0]          pos;
  } token_t;

endpackage

>>> design/pssr_cell.sv
// ----------------------------------------------------------------------------
// pssr_cell
// One slot of a sorted set: holds an entry, processes the passing token and
// hands it, registered, to the next slot in the following cycle.
// ----------------------------------------------------------------------------
module pssr_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CW-1:0]   count_i,
  input  pssr_pkg::token_t tok_i,
  output pssr_pkg::token_t tok_o
);

  logic [pssr_pkg::ValueW-1:0] entry_q;
  pssr_pkg::token_t            tok_q, tok_d;
  logic                        wr_en;
  logic                        ent_vld;
  logic                        ent_eq;
  logic                        ent_gt;

  assign ent_vld = (count_i > CW'(IDX));
  assign ent_eq  = (entry_q == tok_i.key);
  assign ent_gt  = ($signed(entry_q) > $signed(tok_i.key));

  always_comb begin
    tok_d = tok_i;
    wr_en = 1'b0;
    if (tok_i.vld) begin
      unique case (tok_i.mode)
        pssr_pkg::MODE_SEARCH: begin
          if (!ent_vld) begin
            // ran past the last entry: value absent
            tok_d.mode = pssr_pkg::MODE_DONE;
            tok_d.pos  = '0;
            if (tok_i.func == pssr_pkg::FUNC_LOOKUP) begin
              tok_d.status = pssr_pkg::ST_LOOKUP;
            end else if (tok_i.full) begin
              tok_d.status = pssr_pkg::ST_FULL;
            end else begin
              wr_en        = 1'b1;
              tok_d.status = pssr_pkg::ST_INSERTED;
            end
          end else if (ent_eq) begin
            tok_d.mode = pssr_pkg::MODE_DONE;
            if (tok_i.func == pssr_pkg::FUNC_LOOKUP) begin
              tok_d.status = pssr_pkg::ST_LOOKUP;
              tok_d.pos    = pssr_pkg::PosW'(IDX + 1);
            end else begin
              tok_d.status = pssr_pkg::ST_PRESENT;
              tok_d.pos    = '0;
            end
          end else if (ent_gt) begin
            tok_d.pos = '0;
            if (tok_i.func == pssr_pkg::FUNC_LOOKUP) begin
              tok_d.mode   = pssr_pkg::MODE_DONE;
              tok_d.status = pssr_pkg::ST_LOOKUP;
            end else if (tok_i.full) begin
              tok_d.mode   = pssr_pkg::MODE_DONE;
              tok_d.status = pssr_pkg::ST_FULL;
            end else begin
              // drop the key here and carry the displaced entry onward
              wr_en      = 1'b1;
              tok_d.key  = entry_q;
              tok_d.mode = pssr_pkg::MODE_SHIFT;
            end
          end
        end
        pssr_pkg::MODE_SHIFT: begin
          wr_en = 1'b1;
          if (ent_vld) begin
            tok_d.key = entry_q;
          end else begin
            tok_d.mode   = pssr_pkg::MODE_DONE;
            tok_d.status = pssr_pkg::ST_INSERTED;
            tok_d.pos    = '0;
          end
        end
        pssr_pkg::MODE_DONE: begin
          tok_d = tok_i;
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= tok_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> design/pssr_chain.sv
// ----------------------------------------------------------------------------
// pssr_chain
// A row of slots holding one ascending set; the token enters at slot zero
// and leaves the last slot with its answer.
// ----------------------------------------------------------------------------
module pssr_chain #(
  parameter int unsigned SET_DEPTH = 64,
  parameter int unsigned CW        = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CW-1:0]    count_i,
  input  pssr_pkg::token_t tok_i,
  output pssr_pkg::token_t tok_o
);

  pssr_pkg::token_t link [SET_DEPTH+1];

  assign link[0] = tok_i;

  for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
    pssr_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_i),
      .tok_i   (link[g]),
      .tok_o   (link[g+1])
    );
  end

  assign tok_o = link[SET_DEPTH];

endmodule

>>> design/parity_split_sorted_set_rank.sv
// ----------------------------------------------------------------------------
// parity_split_sorted_set_rank
// Two bounded ascending sets of signed 32-bit values, split by parity, with
// insert and 1-based rank lookup.
//
//   channel   signals                                   handshake
//   command   start_i, func_i, value_i                  start_i & !busy_o
//   result    strobe_o, status_o, position_o, odd_set_o one-cycle strobe
//
// Each transaction walks the slot chain of its set, one slot per cycle, so the
// chain length sets when a result is shown and when the next command can be
// taken. busy_o is high for the whole walk and drops in the cycle the result
// is shown, so a new command can be taken in that cycle.
// Reset empties both sets at once; there is no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module parity_split_sorted_set_rank #(
  parameter int unsigned SET_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     func_i,
  input  logic signed [31:0]       value_i,
  output logic                     strobe_o,
  output logic [1:0]               status_o,
  output logic [6:0]               position_o,
  output logic                     odd_set_o
);

  localparam int unsigned CW = $clog2(SET_DEPTH + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    even_cnt_q, even_cnt_d;
  logic [CW-1:0]    odd_cnt_q, odd_cnt_d;
  pssr_pkg::token_t in_tok_q, in_tok_d;
  pssr_pkg::token_t even_in, odd_in, even_out, odd_out, end_tok;
  logic             strobe_q, strobe_d;
  logic [1:0]       status_q, status_d;
  logic [6:0]       pos_q, pos_d;
  logic             odd_q, odd_d;
  logic             accept;

  assign accept = start_i && !busy_q;

  // load the token for an accepted command
  always_comb begin
    in_tok_d      = '0;
    in_tok_d.vld  = accept;
    in_tok_d.mode = pssr_pkg::MODE_SEARCH;
    in_tok_d.func = func_i;
    in_tok_d.odd  = value_i[0];
    in_tok_d.key  = value_i;
    in_tok_d.full = value_i[0] ? (odd_cnt_q == CW'(SET_DEPTH))
                               : (even_cnt_q == CW'(SET_DEPTH));
  end

  always_comb begin
    even_in     = in_tok_q;
    even_in.vld = in_tok_q.vld && !in_tok_q.odd;
    odd_in      = in_tok_q;
    odd_in.vld  = in_tok_q.vld && in_tok_q.odd;
  end

  pssr_chain #(
    .SET_DEPTH (SET_DEPTH),
    .CW        (CW)
  ) u_even (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (even_cnt_q),
    .tok_i   (even_in),
    .tok_o   (even_out)
  );

  pssr_chain #(
    .SET_DEPTH (SET_DEPTH),
    .CW        (CW)
  ) u_odd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (odd_cnt_q),
    .tok_i   (odd_in),
    .tok_o   (odd_out)
  );

  assign end_tok = odd_out.vld ? odd_out : even_out;

  // finish the transaction and bump the count of the set that grew
  always_comb begin
    strobe_d   = end_tok.vld;
    odd_d      = end_tok.odd;
    status_d   = end_tok.status;
    pos_d      = end_tok.pos;
    busy_d     = busy_q;
    even_cnt_d = even_cnt_q;
    odd_cnt_d  = odd_cnt_q;
    if (end_tok.mode == pssr_pkg::MODE_SEARCH) begin
      // walked every slot without a decision: absent, and for an insert the set is full
      pos_d    = '0;
      status_d = (end_tok.func == pssr_pkg::FUNC_LOOKUP) ? pssr_pkg::ST_LOOKUP
                                                         : pssr_pkg::ST_FULL;
    end else if (end_tok.mode == pssr_pkg::MODE_SHIFT) begin
      pos_d    = '0;
      status_d = pssr_pkg::ST_INSERTED;
    end
    if (end_tok.vld) begin
      busy_d = 1'b0;
      if (status_d == pssr_pkg::ST_INSERTED) begin
        if (end_tok.odd) begin
          odd_cnt_d = odd_cnt_q + CW'(1);
        end else begin
          even_cnt_d = even_cnt_q + CW'(1);
        end
      end
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      even_cnt_q <= '0;
      odd_cnt_q  <= '0;
      in_tok_q   <= '0;
      strobe_q   <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      even_cnt_q <= even_cnt_d;
      odd_cnt_q  <= odd_cnt_d;
      in_tok_q   <= in_tok_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
    odd_q    <= odd_d;
  end

  assign busy_o     = busy_q;
  assign strobe_o   = strobe_q;
  assign status_o   = status_q;
  assign position_o = pos_q;
  assign odd_set_o  = odd_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy_o)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (even_cnt_q <= CW'(SET_DEPTH)) && (odd_cnt_q <= CW'(SET_DEPTH)))
    else $error("set count beyond depth");

  a_pos_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (status_o != pssr_pkg::ST_LOOKUP)) |-> (position_o == '0))
    else $error("insert result carries a rank");

  a_one_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(even_out.vld && odd_out.vld))
    else $error("both chains hold a token");

endmodule
